// ----- hw/rtl/arp_reply_learning_table_unit_defines.svh -----
// Assertion macros shared by the ARP reply learning table RTL.
// Included by the top level; depends on nothing else.
`ifndef ARP_REPLY_LEARNING_TABLE_UNIT_DEFINES_SVH
`define ARP_REPLY_LEARNING_TABLE_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define ARPLT_ALWAYS(LABEL, CLK, RST, COND, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (COND)) \
    else $error(MSG);

// A consequence that must hold in the same cycle as its cause.
`define ARPLT_IMPLIES(LABEL, CLK, RST, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |-> (CONS)) \
    else $error(MSG);

// A consequence that must hold in the cycle after its cause.
`define ARPLT_NEXT(LABEL, CLK, RST, ANTE, CONS, MSG) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |=> (CONS)) \
    else $error(MSG);

`endif

// ----- hw/rtl/arplt_pkg.sv -----
// Types and constants of the ARP reply learning table.
// Used by the top level; depends on nothing else.
`timescale 1ns / 1ps

package arplt_pkg;

  // Input item modes.
  localparam logic MODE_FRAME  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // Result item kinds.
  localparam logic KIND_LOOKUP  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Configuration register indexes (address bit 2).
  localparam logic REG_OWN_IP      = 1'b0;
  localparam logic REG_SUBNET_MASK = 1'b1;

  // ARP reply recognition.
  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
  localparam logic [15:0] OPCODE_REPLY  = 16'd2;

  // Byte positions inside the frame, first byte at position zero.
  localparam logic [5:0] POS_ETHERTYPE      = 6'd12;
  localparam logic [5:0] POS_ETHERTYPE_END  = 6'd13;
  localparam logic [5:0] POS_OPCODE         = 6'd20;
  localparam logic [5:0] POS_OPCODE_END     = 6'd21;
  localparam logic [5:0] POS_SENDER_MAC     = 6'd22;
  localparam logic [5:0] POS_SENDER_MAC_END = 6'd27;
  localparam logic [5:0] POS_SENDER_IP      = 6'd28;
  localparam logic [5:0] POS_SENDER_IP_END  = 6'd31;
  // Position of the last byte of the shortest acceptable frame (42 bytes).
  localparam logic [5:0] POS_MIN_LAST       = 6'd41;
  localparam logic [5:0] COUNT_MAX          = 6'd63;

  // Result queue depth and its pointer and count widths.
  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One result item.
  typedef struct packed {
    logic        kind;
    logic        hit;
    logic [47:0] mac_addr;
    logic        learned;
  } result_t;

endpackage

// ----- hw/rtl/arplt_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; used by the ARP reply learning table for its entry store.
`timescale 1ns / 1ps

module arplt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; a write is visible to reads from the next edge on.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/arp_reply_learning_table_unit.sv -----
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   mode, frame_byte, frame_last, query_ip
// result    out        out_valid/out_stall kind, hit, mac_addr, learned
// config    in         APB psel/penable    own address at 0x0, subnet_mask at 0x4
//
// One item is accepted per cycle while in_stall is low. A result passes the input
// register, the reciprocal multiply for the table index and the RAM read, each
// registered, and is then written into the result queue. After reset a clearing
// pass writes every table entry once, with in_stall high. in_stall also rises when
// the eight-entry result queue could not hold the transactions in flight.
//
// Depends on arplt_pkg, arplt_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "arp_reply_learning_table_unit_defines.svh"

module arp_reply_learning_table_unit #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  frame_byte,
  input  logic        frame_last,
  input  logic [31:0] query_ip,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic        hit,
  output logic [47:0] mac_addr,
  output logic        learned,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import arplt_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  // Index = ip mod TABLE_ENTRIES by reciprocal: q = (ip * RECIP) >> K is the
  // true quotient or one less, so one compare and subtract finishes it.
  localparam int K = 31 + AW;
  localparam logic [63:0] RECIP_WIDE = (64'd1 << K) / 64'(TABLE_ENTRIES);
  localparam logic [31:0] RECIP = RECIP_WIDE[31:0];
  localparam logic [AW:0] N_W = (AW + 1)'(TABLE_ENTRIES);
  localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_ENTRIES - 1);

  // Configuration registers.
  logic [31:0] own_ip;
  logic [31:0] subnet_mask;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SUBNET_MASK) ? subnet_mask : own_ip;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip      <= '0;
      subnet_mask <= '0;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_OWN_IP:      own_ip      <= pwdata;
        REG_SUBNET_MASK: subnet_mask <= pwdata;
        default:         own_ip      <= own_ip;
      endcase
    end
  end

  // Clearing pass over the table after reset.
  logic          clr_active;
  logic [AW-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_active) begin
      if (clr_idx == CLR_LAST) begin
        clr_active <= 1'b0;
      end else begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // Input handshake and occupancy of the pipeline plus result queue.
  logic                 in_accept;
  logic                 v1, v2, v3;
  logic [RES_CNT_W-1:0] fifo_count;
  logic [RES_CNT_W:0]   occupancy;

  assign occupancy = (RES_CNT_W + 1)'(fifo_count) + (RES_CNT_W + 1)'(v1)
                   + (RES_CNT_W + 1)'(v2) + (RES_CNT_W + 1)'(v3);
  assign in_stall  = clr_active || (occupancy >= (RES_CNT_W + 1)'(RES_DEPTH));
  assign in_accept = in_valid && !in_stall;

  // Frame capture registers.
  logic [5:0]  byte_count, byte_count_next;
  logic [15:0] cap_etype, cap_etype_next;
  logic [15:0] cap_opcode, cap_opcode_next;
  logic [47:0] cap_mac, cap_mac_next;
  logic [31:0] cap_ip, cap_ip_next;
  logic        frame_ok;

  // The verdict depends only on bytes before position 32, so the registered
  // captures already hold them whenever the length test can pass.
  assign frame_ok = (byte_count >= POS_MIN_LAST)
                 && (cap_etype == ETHERTYPE_ARP)
                 && (cap_opcode == OPCODE_REPLY)
                 && ((cap_ip & subnet_mask) == (own_ip & subnet_mask));

  always_comb begin
    byte_count_next = byte_count;
    cap_etype_next  = cap_etype;
    cap_opcode_next = cap_opcode;
    cap_mac_next    = cap_mac;
    cap_ip_next     = cap_ip;
    if (in_accept && mode == MODE_FRAME) begin
      if (frame_last) begin
        byte_count_next = '0;
        cap_etype_next  = '0;
        cap_opcode_next = '0;
        cap_mac_next    = '0;
        cap_ip_next     = '0;
      end else begin
        if (byte_count inside {[POS_ETHERTYPE:POS_ETHERTYPE_END]}) begin
          cap_etype_next = {cap_etype[7:0], frame_byte};
        end else if (byte_count inside {[POS_OPCODE:POS_OPCODE_END]}) begin
          cap_opcode_next = {cap_opcode[7:0], frame_byte};
        end else if (byte_count inside {[POS_SENDER_MAC:POS_SENDER_MAC_END]}) begin
          cap_mac_next = {cap_mac[39:0], frame_byte};
        end else if (byte_count inside {[POS_SENDER_IP:POS_SENDER_IP_END]}) begin
          cap_ip_next = {cap_ip[23:0], frame_byte};
        end
        if (byte_count != COUNT_MAX) begin
          byte_count_next = byte_count + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      cap_etype  <= '0;
      cap_opcode <= '0;
      cap_mac    <= '0;
      cap_ip     <= '0;
    end else begin
      byte_count <= byte_count_next;
      cap_etype  <= cap_etype_next;
      cap_opcode <= cap_opcode_next;
      cap_mac    <= cap_mac_next;
      cap_ip     <= cap_ip_next;
    end
  end

  // Stage 1: items that give a result, lookups and last frame bytes.
  logic        kind1, ok1;
  logic [31:0] ip1;
  logic [47:0] mac1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_accept && (mode == MODE_LOOKUP || frame_last);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind1 <= (mode == MODE_LOOKUP) ? KIND_LOOKUP : KIND_VERDICT;
      ok1   <= frame_ok;
      ip1   <= (mode == MODE_LOOKUP) ? query_ip : cap_ip;
      mac1  <= cap_mac;
    end
  end

  // Stage 2: reciprocal multiply, keeping the low quotient bits.
  logic [63:0] prod;
  logic        kind2, ok2;
  logic [31:0] ip2;
  logic [47:0] mac2;
  logic [AW:0] q2;

  assign prod = 64'(ip1) * 64'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    kind2 <= kind1;
    ok2   <= ok1;
    ip2   <= ip1;
    mac2  <= mac1;
    q2    <= prod[K+AW:K];
  end

  // Remainder and its correction give the table index; the RAM is written
  // for a learned reply and read for a lookup, both in this stage so that
  // transactions see the table in arrival order.
  logic [AW:0]    qn;
  logic [AW:0]    rem;
  logic [AW-1:0]  idx2;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  entry_t         ram_wentry;
  logic [ENTRY_W-1:0] ram_rdata;

  assign qn   = (AW + 1)'(q2 * N_W);
  assign rem  = ip2[AW:0] - qn;
  assign idx2 = (rem >= N_W) ? AW'(rem - N_W) : AW'(rem);

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = idx2;
    ram_wentry = '0;
    if (clr_active) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
    end else if (v2 && kind2 == KIND_VERDICT && ok2) begin
      ram_we           = 1'b1;
      ram_wentry.valid = 1'b1;
      ram_wentry.ip    = ip2;
      ram_wentry.mac   = mac2;
    end
  end

  arplt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (idx2),
    .rdata (ram_rdata)
  );

  // Stage 3: compare the read entry and build the result.
  logic        kind3, ok3;
  logic [31:0] ip3;
  entry_t      rd_entry;
  logic        hit3;
  result_t     res3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    kind3 <= kind2;
    ok3   <= ok2;
    ip3   <= ip2;
  end

  assign rd_entry = entry_t'(ram_rdata);
  assign hit3     = (kind3 == KIND_LOOKUP) && rd_entry.valid && (rd_entry.ip == ip3);

  always_comb begin
    res3.kind     = kind3;
    res3.hit      = hit3;
    res3.mac_addr = hit3 ? rd_entry.mac : 48'd0;
    res3.learned  = (kind3 == KIND_VERDICT) && ok3;
  end

  // Result queue between the pipeline and the output channel.
  result_t              fifo_mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr, rd_ptr;
  logic                 pop;
  result_t              head;

  assign out_valid = (fifo_count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = fifo_mem[rd_ptr];
  assign kind      = head.kind;
  assign hit       = head.hit;
  assign mac_addr  = head.mac_addr;
  assign learned   = head.learned;

  always_ff @(posedge clk) begin
    if (v3) begin
      fifo_mem[wr_ptr] <= res3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (v3) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({v3, pop})
        2'b10:   fifo_count <= fifo_count + 1'b1;
        2'b01:   fifo_count <= fifo_count - 1'b1;
        default: fifo_count <= fifo_count;
      endcase
    end
  end

  // Checks on the occupancy accounting, the clearing pass and the results.
  `ARPLT_ALWAYS(a_no_overflow, clk, rst,
                occupancy <= (RES_CNT_W + 1)'(RES_DEPTH), "result queue overrun")
  `ARPLT_IMPLIES(a_clear_empty, clk, rst, clr_active, !v1 && !v2 && !v3,
                 "transaction in flight during table clear")
  `ARPLT_NEXT(a_clear_ends, clk, rst, clr_active && clr_idx == CLR_LAST, !clr_active,
              "table clear did not finish")
  `ARPLT_IMPLIES(a_verdict_clean, clk, rst, v3 && kind3 == KIND_VERDICT,
                 !res3.hit && res3.mac_addr == 48'd0, "verdict carries lookup data")

endmodule

// ----- tb/sv/arp_reply_learning_table_unit_checker.sv -----
`timescale 1ns / 1ps
// Checker for the ARP reply learning table: it mirrors the frame capture, the table
// and the address registers, and compares every result transaction.
// Depends on arplt_pkg.

module arp_reply_learning_table_unit_checker #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  frame_byte,
  input  logic        frame_last,
  input  logic [31:0] query_ip,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        kind,
  input  logic        hit,
  input  logic [47:0] mac_addr,
  input  logic        learned,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          answers_pending,
  output int          answers_checked,
  output int          hits_seen,
  output int          frames_learned
);

  import arplt_pkg::*;

  // Mirrored address registers.
  logic [31:0] own_ip;
  logic [31:0] own_mask;

  // Mirrored learning table.
  logic [31:0] arp_ip    [TABLE_ENTRIES];
  logic [47:0] arp_mac   [TABLE_ENTRIES];
  logic        arp_valid [TABLE_ENTRIES];

  // Mirrored capture of the frame in progress.
  logic [5:0]  byte_pos;
  logic [15:0] cap_ethertype;
  logic [15:0] cap_opcode;
  logic [47:0] cap_sender_mac;
  logic [31:0] cap_sender_ip;

  // Answers and verdicts still owed by the block, oldest first.
  result_t answers_due [$];

  int errors;
  int checked;
  int hits;
  int learns;

  // Table slot of an address: the address modulo the table size.
  function automatic int slot_of(input logic [31:0] ip);
    return int'(ip % 32'(TABLE_ENTRIES));
  endfunction

  // Answer to a lookup of one address.
  function automatic result_t answer_lookup(input logic [31:0] ip);
    result_t answer;
    int      slot;
    slot            = slot_of(ip);
    answer          = '0;
    answer.kind     = KIND_LOOKUP;
    answer.hit      = arp_valid[slot] && arp_ip[slot] == ip;
    answer.mac_addr = answer.hit ? arp_mac[slot] : 48'h0;
    return answer;
  endfunction

  // Capture one frame byte; on the last byte, judge the frame and learn the sender.
  function automatic void take_frame_byte(input logic [7:0] b, input logic last);
    logic [5:0] pos;
    logic       ok;
    int         slot;
    result_t    verdict;
    pos = byte_pos;
    if (pos >= POS_ETHERTYPE && pos <= POS_ETHERTYPE_END) begin
      cap_ethertype = {cap_ethertype[7:0], b};
    end else if (pos >= POS_OPCODE && pos <= POS_OPCODE_END) begin
      cap_opcode = {cap_opcode[7:0], b};
    end else if (pos >= POS_SENDER_MAC && pos <= POS_SENDER_MAC_END) begin
      cap_sender_mac = {cap_sender_mac[39:0], b};
    end else if (pos >= POS_SENDER_IP && pos <= POS_SENDER_IP_END) begin
      cap_sender_ip = {cap_sender_ip[23:0], b};
    end
    if (byte_pos < COUNT_MAX) begin
      byte_pos = byte_pos + 6'd1;
    end
    if (!last) begin
      return;
    end
    // The frame must reach the minimum length, be an ARP reply and come from the subnet.
    ok = pos >= POS_MIN_LAST && cap_ethertype == ETHERTYPE_ARP && cap_opcode == OPCODE_REPLY
      && (cap_sender_ip & own_mask) == (own_ip & own_mask);
    if (ok) begin
      slot            = slot_of(cap_sender_ip);
      arp_ip[slot]    = cap_sender_ip;
      arp_mac[slot]   = cap_sender_mac;
      arp_valid[slot] = 1'b1;
      learns++;
    end
    verdict         = '0;
    verdict.kind    = KIND_VERDICT;
    verdict.learned = ok;
    answers_due.push_back(verdict);
    byte_pos       = '0;
    cap_ethertype  = '0;
    cap_opcode     = '0;
    cap_sender_mac = '0;
    cap_sender_ip  = '0;
  endfunction

  // Results are checked before new transactions are predicted, so a result can never
  // match an item accepted at the same edge.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      own_ip         = '0;
      own_mask       = '0;
      byte_pos       = '0;
      cap_ethertype  = '0;
      cap_opcode     = '0;
      cap_sender_mac = '0;
      cap_sender_ip  = '0;
      foreach (arp_valid[i]) begin
        arp_valid[i] = 1'b0;
        arp_ip[i]    = '0;
        arp_mac[i]   = '0;
      end
      answers_due.delete();
      errors  = 0;
      checked = 0;
      hits    = 0;
      learns  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.kind     = kind;
        got.hit      = hit;
        got.mac_addr = mac_addr;
        got.learned  = learned;
        if (answers_due.size() == 0) begin
          $error("result transaction with none expected: kind %0d hit %0d mac %h learned %0d",
                 kind, hit, mac_addr, learned);
          errors++;
        end else begin
          want = answers_due.pop_front();
          checked++;
          if (want.hit) begin
            hits++;
          end
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
          end
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, got.hit);
            errors++;
          end
          if (got.mac_addr !== want.mac_addr) begin
            $error("mac_addr: expected %h, got %h", want.mac_addr, got.mac_addr);
            errors++;
          end
          if (got.learned !== want.learned) begin
            $error("learned: expected %0d, got %0d", want.learned, got.learned);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (mode == MODE_LOOKUP) begin
          answers_due.push_back(answer_lookup(query_ip));
        end else begin
          take_frame_byte(frame_byte, frame_last);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_OWN_IP) begin
          own_ip = pwdata;
        end else begin
          own_mask = pwdata;
        end
      end
    end
    fail_count      <= errors;
    answers_pending <= answers_due.size();
    answers_checked <= checked;
    hits_seen       <= hits;
    frames_learned  <= learns;
  end

endmodule

// ----- tb/sv/arp_reply_learning_table_unit_tb.sv -----
`timescale 1ns / 1ps
// Top of the ARP reply learning table testbench: clock, reset, register writes,
// frame and lookup stimulus, result stalls, watchdog and verdict.
// Depends on arplt_pkg, the block and arp_reply_learning_table_unit_checker.

module arp_reply_learning_table_unit_tb;
  import arplt_pkg::*;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDLE_LIMIT    = 10000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_COUNT   = 5;
  localparam int PHASE_ITEMS   = 210;
  localparam int POOL_SIZE     = 64;

  // Address and mask for each phase; the last phase runs without random idle gaps or stall bursts.
  localparam logic [31:0] PHASE_IP [PHASE_COUNT] =
    '{32'hC0A8_0001, 32'h5A5A_A5A5, 32'h0A00_0005, 32'hFFFF_FFFF, 32'h0000_0000};
  localparam logic [31:0] PHASE_MASK [PHASE_COUNT] =
    '{32'hFFFF_FF00, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'hFFFF_FFF0};

  logic        clk;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic        mode       = MODE_FRAME;
  logic [7:0]  frame_byte = '0;
  logic        frame_last = 1'b0;
  logic [31:0] query_ip   = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic        kind;
  logic        hit;
  logic [47:0] mac_addr;
  logic        learned;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [2:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        idle_en     = 1'b1;
  int          stall_left  = 0;
  int          idle_cycles = 0;
  int          items_sent  = 0;
  logic [31:0] cur_ip      = '0;
  logic [31:0] cur_mask    = '0;
  logic [31:0] sender_pool [$];

  int fail_count;
  int answers_pending;
  int answers_checked;
  int hits_seen;
  int frames_learned;

  arp_reply_learning_table_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .frame_byte(frame_byte),
    .frame_last(frame_last), .query_ip(query_ip),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .hit(hit),
    .mac_addr(mac_addr), .learned(learned),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  arp_reply_learning_table_unit_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .frame_byte(frame_byte),
    .frame_last(frame_last), .query_ip(query_ip),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .hit(hit),
    .mac_addr(mac_addr), .learned(learned),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .fail_count(fail_count), .answers_pending(answers_pending),
    .answers_checked(answers_checked), .hits_seen(hits_seen),
    .frames_learned(frames_learned)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side stalls in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 15);
    end
  end

  // Watchdog: too long without any accepted transaction ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("arp_reply_learning_table_unit_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One input transaction, after an optional random gap.
  task automatic send_item(input logic m, input logic [7:0] b, input logic l,
                           input logic [31:0] q);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    frame_byte <= b;
    frame_last <= l;
    query_ip   <= q;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_lookup(input logic [31:0] ip);
    send_item(MODE_LOOKUP, 8'($urandom), 1'($urandom), ip);
  endtask

  // A random address inside the current subnet.
  function automatic logic [31:0] subnet_ip();
    return (cur_ip & cur_mask) | ($urandom & ~cur_mask);
  endfunction

  // An address outside the subnet: flip the lowest masked bit.
  function automatic logic [31:0] foreign_ip();
    if (cur_mask == '0) begin
      return $urandom;
    end
    return subnet_ip() ^ (cur_mask & (~cur_mask + 32'd1));
  endfunction

  // Lookup targets: known senders, same-slot aliases, the extremes and random ones.
  function automatic logic [31:0] pick_query();
    int          r;
    logic [31:0] known;
    r     = $urandom_range(0, 9);
    known = sender_pool.size() > 0 ? sender_pool[$urandom_range(0, sender_pool.size() - 1)]
                                   : subnet_ip();
    if (r < 5) begin
      return known;
    end else if (r < 7) begin
      return known ^ (32'h1 << $urandom_range(10, 31));
    end else if (r == 7) begin
      return $urandom;
    end else if (r == 8) begin
      return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    end
    return subnet_ip();
  endfunction

  // One frame with the given header fields; other bytes are random. Lookups may
  // slip in between the bytes.
  task automatic send_frame(input int len, input logic [15:0] etype, input logic [15:0] opc,
                            input logic [47:0] smac, input logic [31:0] sip);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i >= POS_ETHERTYPE && i <= POS_ETHERTYPE_END) begin
        b = etype[8 * (POS_ETHERTYPE_END - i) +: 8];
      end else if (i >= POS_OPCODE && i <= POS_OPCODE_END) begin
        b = opc[8 * (POS_OPCODE_END - i) +: 8];
      end else if (i >= POS_SENDER_MAC && i <= POS_SENDER_MAC_END) begin
        b = smac[8 * (POS_SENDER_MAC_END - i) +: 8];
      end else if (i >= POS_SENDER_IP && i <= POS_SENDER_IP_END) begin
        b = sip[8 * (POS_SENDER_IP_END - i) +: 8];
      end
      if (i > 0 && $urandom_range(0, 29) == 0) begin
        send_lookup(pick_query());
      end
      send_item(MODE_FRAME, b, i == len - 1, $urandom);
    end
  endtask

  task automatic remember_sender(input logic [31:0] ip);
    sender_pool.push_back(ip);
    if (sender_pool.size() > POOL_SIZE) begin
      void'(sender_pool.pop_front());
    end
  endtask

  // Hold the sender until every owed result has come, then let the pipeline empty.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: setup phase, access phase until pready, then an idle phase.
  task automatic reg_write(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // One random step: mostly good replies, some broken frames, noise and lookups.
  task automatic random_step();
    int          r;
    int          len;
    logic [15:0] etype;
    logic [15:0] opc;
    logic [31:0] ip;
    logic [47:0] smac;
    r     = $urandom_range(0, 99);
    smac  = {16'($urandom), 32'($urandom)};
    etype = ETHERTYPE_ARP;
    opc   = OPCODE_REPLY;
    len   = 42 + $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(43, 90);
    end
    if (r < 55) begin
      ip = subnet_ip();
      if (sender_pool.size() > 0 && $urandom_range(0, 5) == 0) begin
        ip = sender_pool[$urandom_range(0, sender_pool.size() - 1)];
      end
      send_frame(len, etype, opc, smac, ip);
      remember_sender(ip);
      if ($urandom_range(0, 1)) begin
        send_lookup(ip);
      end
    end else if (r < 70) begin
      ip = subnet_ip();
      case ($urandom_range(0, 3))
        0: etype = ETHERTYPE_ARP ^ (16'h1 << $urandom_range(0, 15));
        1: opc = $urandom_range(0, 1) ? 16'd1 : OPCODE_REPLY ^ (16'h1 << $urandom_range(0, 15));
        2: len = $urandom_range(0, 1) ? 41 : $urandom_range(1, 41);
        default: ip = foreign_ip();
      endcase
      send_frame(len, etype, opc, smac, ip);
    end else if (r < 75) begin
      send_frame($urandom_range(1, 80), 16'($urandom), 16'($urandom), smac, $urandom);
    end else begin
      repeat ($urandom_range(1, 4)) send_lookup(pick_query());
    end
  endtask

  initial begin
    int phase_end;
    int half_mark;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p > 0) begin
        drain();
      end
      if (p == PHASE_COUNT - 1) begin
        idle_en <= 1'b0;
      end
      cur_ip   = PHASE_IP[p];
      cur_mask = PHASE_MASK[p];
      reg_write(REG_OWN_IP, cur_ip);
      reg_write(REG_SUBNET_MASK, cur_mask);
      if (p == 0) begin
        // Lookups into an empty table, the shortest frames, and a lookup inside a frame.
        send_lookup(32'h0);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(32'h0000_03FF);
        send_item(MODE_FRAME, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        send_item(MODE_FRAME, 8'h00, 1'b1, 32'h0);
        send_item(MODE_FRAME, 8'hA5, 1'b0, 32'h0);
        send_lookup(cur_ip);
        send_item(MODE_FRAME, 8'h5A, 1'b1, 32'h0);
        // A reply of minimum length, one a byte short, and one past the count limit.
        send_frame(42, ETHERTYPE_ARP, OPCODE_REPLY, 48'hFFFF_FFFF_FFFF, cur_ip);
        send_lookup(cur_ip);
        send_frame(41, ETHERTYPE_ARP, OPCODE_REPLY, 48'h0, cur_ip ^ 32'h1);
        send_lookup(cur_ip ^ 32'h1);
        send_frame(70, ETHERTYPE_ARP, OPCODE_REPLY, 48'h0123_4567_89AB, cur_ip ^ 32'h2);
        send_lookup(cur_ip ^ 32'h2);
        remember_sender(cur_ip);
        remember_sender(cur_ip ^ 32'h2);
      end
      // Phase targets count from the start of the run, so overshoot does not add up.
      phase_end = (p + 1) * PHASE_ITEMS;
      half_mark = p * PHASE_ITEMS + PHASE_ITEMS / 2;
      while (items_sent < phase_end) begin
        // Once per phase the sender waits for the result side to catch up.
        if (half_mark != 0 && items_sent >= half_mark) begin
          drain();
          half_mark = 0;
        end
        random_step();
      end
    end
    drain();
    $display("Run sent %0d input transactions under %0d address and mask settings.",
             items_sent, PHASE_COUNT);
    $display("Checked %0d results with %0d lookup hits and %0d frames learned.",
             answers_checked, hits_seen, frames_learned);
    if (fail_count == 0) begin
      $display("arp_reply_learning_table_unit_tb passed");
    end else begin
      $display("arp_reply_learning_table_unit_tb failed");
    end
    $finish;
  end

endmodule

// ----- arp_reply_learning_table_unit.f -----
+incdir+hw/rtl
hw/rtl/arplt_pkg.sv
hw/rtl/arplt_ram.sv
hw/rtl/arp_reply_learning_table_unit.sv
tb/sv/arp_reply_learning_table_unit_checker.sv
tb/sv/arp_reply_learning_table_unit_tb.sv
